[hdl/trhb_pkg.sv]
// Shared types, widths and constants of the traffic rate history buffer.
`timescale 1ns / 1ps
`default_nettype none

package trhb_pkg;

   localparam int DEFAULT_HISTORY_DEPTH = 64;

   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 32;
   localparam int INTERVAL_W = 16;
   localparam int RATE_W     = 40;
   localparam int BYTES_W    = 64;
   localparam int TIME_W     = 48;
   localparam int FILL_W     = 7;

   // Magnitude of a clamped byte count: the sign bit is never set.
   localparam int MAG_W      = COUNT_W - 1;
   // bytes * 1000 * 256 / (interval * 1024) reduces to bytes * 250 / interval.
   localparam int SCALE_W    = 8;
   localparam logic [SCALE_W-1:0] RATE_SCALE = 8'd250;
   localparam int DIV_STEPS  = RATE_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD        = 2'd0,
      MODE_READ_FIRST = 2'd1,
      MODE_READ_NEXT  = 2'd2,
      MODE_CLEAR      = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [COUNT_W-1:0]     byte_count;
      logic [INTERVAL_W-1:0]         interval_ms;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   rate_value;
      logic                read_valid;
      logic [RATE_W-1:0]   peak_rate;
      logic [BYTES_W-1:0]  byte_total;
      logic [TIME_W-1:0]   time_total;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULTIPLY,
      ST_DIVIDE,
      ST_READ,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic div_step;
      logic read_issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[hdl/trhb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module trhb_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/trhb_ctrl.sv]
// Sequencing state machine of the traffic rate history buffer.
`timescale 1ns / 1ps
`default_nettype none

module trhb_ctrl
   import trhb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire mode_type   req_mode,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  MODE_ADD:                        state_in = ST_MULTIPLY;
                  MODE_READ_FIRST, MODE_READ_NEXT: state_in = ST_READ;
                  MODE_CLEAR:                      state_in = ST_COMMIT;
                  default:                         state_in = ST_COMMIT;
               endcase
            end
         end
         ST_MULTIPLY: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_READ: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MULTIPLY: cmd.multiply   = 1'b1;
         ST_DIVIDE:   cmd.div_step   = 1'b1;
         ST_READ:     cmd.read_issue = 1'b1;
         ST_COMMIT:   cmd.commit     = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/trhb_dp.sv]
// Datapath: rate divider, history ring, totals, peak and result register.
`timescale 1ns / 1ps
`default_nettype none

module trhb_dp
   import trhb_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int CUR_W  = $clog2(HISTORY_DEPTH + 2);
   localparam int POS_W  = ADDR_W + 1;

   // Captured item.
   mode_type              mode_ff;
   logic [MAG_W-1:0]      bytes_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // Divider.
   logic [RATE_W-1:0]     quo_ff, quo_in;
   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff;
   logic [INTERVAL_W:0]   trial;
   logic                  trial_ge;

   // Architectural state.
   logic [ADDR_W-1:0]     newest_ff, newest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CUR_W-1:0]      cursor_ff, cursor_in;
   logic [RATE_W-1:0]     peak_ff, peak_in;
   logic [BYTES_W-1:0]    bytes_total_ff, bytes_total_in;
   logic [TIME_W-1:0]     time_total_ff, time_total_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [BYTES_W:0]      bytes_sum;
   logic [TIME_W:0]       time_sum;
   logic [RATE_W-1:0]     add_rate;
   logic [CUR_W-1:0]      cursor_next, age_full;
   logic [ADDR_W-1:0]     age;
   logic [POS_W-1:0]      pos_wrap;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  read_hit;
   logic [RATE_W-1:0]     ram_q;
   logic                  ring_write;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_data.mode;
         bytes_ff    <= req_data.byte_count[COUNT_W-1] ? '0 : req_data.byte_count[MAG_W-1:0];
         interval_ff <= req_data.interval_ms;
      end
   end

   // Restoring division, one quotient bit per cycle. The dividend enters the
   // quotient register and shifts out at the top as quotient bits shift in.
   // A zero divisor sets every quotient bit, and the rate is forced to full
   // scale anyway.
   assign trial    = {rem_ff, quo_ff[RATE_W-1]};
   assign trial_ge = trial >= {1'b0, interval_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.multiply) begin
         quo_in = RATE_W'(bytes_ff * RATE_SCALE);
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[RATE_W-2:0], trial_ge};
         rem_in = trial_ge ? INTERVAL_W'(trial - {1'b0, interval_ff}) : trial[INTERVAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.multiply) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   assign status.div_last = step_ff == STEP_W'(DIV_STEPS - 1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Read addressing: the cursor counts entries already read, so the entry
   // wanted has age cursor - 1 behind the newest position.
   always_comb begin
      if (mode_ff == MODE_READ_FIRST) begin
         cursor_next = CUR_W'(1);
         read_hit    = count_ff != '0;
      end else begin
         cursor_next = (cursor_ff < CUR_W'(HISTORY_DEPTH + 1)) ? cursor_ff + 1'b1 : cursor_ff;
         read_hit    = cursor_next <= CUR_W'(count_ff);
      end
      age_full = cursor_next - 1'b1;
      age      = age_full[ADDR_W-1:0];
      pos_wrap = POS_W'(newest_ff) + POS_W'(HISTORY_DEPTH) - POS_W'(age);
      rd_addr  = (newest_ff >= age) ? newest_ff - age : pos_wrap[ADDR_W-1:0];
   end

   assign newest_in = (newest_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
   assign ring_write = cmd.commit && (mode_ff == MODE_ADD);

   trhb_ram #(
      .WIDTH(RATE_W),
      .DEPTH(HISTORY_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_write),
      .wr_addr(newest_in),
      .wr_data(add_rate),
      .rd_en  (cmd.read_issue),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign bytes_sum = {1'b0, bytes_total_ff} + (BYTES_W + 1)'(bytes_ff);
   assign time_sum  = {1'b0, time_total_ff} + (TIME_W + 1)'(interval_ff);
   assign add_rate  = (interval_ff == '0) ? '1 : quo_ff;

   always_comb begin
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      peak_in        = peak_ff;
      bytes_total_in = bytes_total_ff;
      time_total_in  = time_total_ff;
      rsp_in         = '0;
      unique case (mode_ff)
         MODE_ADD: begin
            if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
            if (add_rate > peak_ff) begin
               peak_in = add_rate;
            end
            bytes_total_in = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
            time_total_in  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
            rsp_in.rate_value = add_rate;
         end
         MODE_READ_FIRST: begin
            if (read_hit) begin
               cursor_in         = cursor_next;
               rsp_in.rate_value = ram_q;
               rsp_in.read_valid = 1'b1;
            end
         end
         MODE_READ_NEXT: begin
            cursor_in = cursor_next;
            if (read_hit) begin
               rsp_in.rate_value = ram_q;
               rsp_in.read_valid = 1'b1;
            end
         end
         MODE_CLEAR: begin
            count_in       = '0;
            cursor_in      = '0;
            peak_in        = '0;
            bytes_total_in = '0;
            time_total_in  = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.peak_rate  = peak_in;
      rsp_in.byte_total = bytes_total_in;
      rsp_in.time_total = time_total_in;
      rsp_in.fill_count = FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff      <= '0;
         count_ff       <= '0;
         cursor_ff      <= '0;
         peak_ff        <= '0;
         bytes_total_ff <= '0;
         time_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (mode_ff == MODE_ADD) begin
               newest_ff <= newest_in;
            end else if (mode_ff == MODE_CLEAR) begin
               newest_ff <= '0;
            end
            count_ff       <= count_in;
            cursor_ff      <= cursor_in;
            peak_ff        <= peak_in;
            bytes_total_ff <= bytes_total_in;
            time_total_ff  <= time_total_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/traffic_rate_history_buffer_top.sv]
// Top level of the traffic rate history buffer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Traffic rate history buffer.
// Requests arrive on the req_ channel (valid/ready) and each one produces
// exactly one transfer on the rsp_ channel. An add request clamps a negative
// byte count to zero, updates the saturating byte and time totals, computes
// the rate bytes*250/interval (KiB/s in Q32.8, full scale for a zero
// interval), pushes it into the history ring and updates the peak. Read-first
// returns the newest ring entry and read-next successively older ones; reads
// past the fill count return zero with read_valid low. Clear zeroes all state.
// One request is worked on at a time. An add runs through the multiply step,
// then the radix-2 divider, which produces one quotient bit per cycle, then
// the commit step. A read issues the registered read of the ring memory and
// then commits; a clear goes straight to commit.
// req_ready returns high in the cycle after the result is loaded, so a new
// request can be accepted while the previous result still waits on rsp_.
// If the receiver stalls, the finished item waits in the commit step until
// the result register is free; rsp_data holds steady while rsp_valid is high.
// Synchronous reset empties the ring (fill count zero), clears the totals,
// the peak and the read cursor, and drops rsp_valid. No clearing pass is
// needed: only entries written since the last reset or clear are ever read.

module traffic_rate_history_buffer_top
   import trhb_pkg::*;
#(
   parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Commands flow from the controller to the datapath; status flows back.
   cmd_type    cmd;
   status_type status;

   trhb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_data.mode),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   trhb_dp #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[verif/traffic_rate_history_buffer_top_tb.sv]
// Self-checking testbench for the traffic rate history buffer top level.
`timescale 1ns / 1ps

// The testbench drives request transfers from a queue and predicts each result
// with its own copy of the history state. It then checks every response transfer
// field by field against the oldest prediction still waiting. The run goes through
// four idling phases: no idling, sender idle, receiver stalling, and both together.

module traffic_rate_history_buffer_top_tb;
   import trhb_pkg::*;

   localparam int DEPTH = DEFAULT_HISTORY_DEPTH;
   localparam int PHASE_ITEMS = 482;
   localparam logic [RATE_W-1:0] RATE_FULL = {RATE_W{1'b1}};
   localparam logic [BYTES_W-1:0] BYTES_FULL = {BYTES_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_FULL = {TIME_W{1'b1}};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   traffic_rate_history_buffer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Requests waiting to be driven, and the responses predicted for accepted ones.
   req_type queued_requests[$];
   rsp_type awaited_results[$];

   int unsigned requests_queued   = 0;
   int unsigned requests_accepted = 0;
   int unsigned mismatch_count    = 0;
   int unsigned send_idle_pct     = 0;
   int unsigned recv_stall_pct    = 0;
   bit          req_taken         = 1'b0;

   // The predictor's own copy of the history state.
   logic [RATE_W-1:0]  history_rates [DEPTH];
   int unsigned        newest_slot;
   int unsigned        stored_entries;
   int unsigned        read_depth;
   logic [RATE_W-1:0]  peak_seen;
   logic [BYTES_W-1:0] bytes_seen;
   logic [TIME_W-1:0]  millis_seen;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Returns every piece of predicted state to its value after reset or clear.
   function automatic void clear_history();
      for (int i = 0; i < DEPTH; i++) begin
         history_rates[i] = '0;
      end
      newest_slot    = 0;
      stored_entries = 0;
      read_depth     = 0;
      peak_seen      = '0;
      bytes_seen     = '0;
      millis_seen    = '0;
   endfunction

   // Works out the response to one accepted request and advances the state.
   function automatic rsp_type next_history_result(req_type item);
      rsp_type                res;
      logic [BYTES_W:0]       byte_sum;
      logic [TIME_W:0]        millis_sum;
      logic [63:0]            clamped;
      logic [63:0]            quotient;
      res = '0;
      case (item.mode)
         MODE_ADD: begin
            // A negative count contributes nothing to the totals or the rate.
            clamped = item.byte_count[COUNT_W-1] ? 64'd0 : {32'd0, item.byte_count};
            byte_sum = {1'b0, bytes_seen} + {1'b0, clamped};
            bytes_seen = byte_sum[BYTES_W] ? BYTES_FULL : byte_sum[BYTES_W-1:0];
            if (item.interval_ms == '0) begin
               res.rate_value = RATE_FULL;
            end else begin
               quotient = (clamped * 64'd250) / {48'd0, item.interval_ms};
               res.rate_value = (quotient > {24'd0, RATE_FULL}) ? RATE_FULL
                                                                : quotient[RATE_W-1:0];
            end
            newest_slot = (newest_slot + 1) % DEPTH;
            history_rates[newest_slot] = res.rate_value;
            if (stored_entries < DEPTH) begin
               stored_entries++;
            end
            if (res.rate_value > peak_seen) begin
               peak_seen = res.rate_value;
            end
            millis_sum = {1'b0, millis_seen} + {33'd0, item.interval_ms};
            millis_seen = millis_sum[TIME_W] ? TIME_FULL : millis_sum[TIME_W-1:0];
         end
         MODE_READ_FIRST: begin
            if (stored_entries != 0) begin
               read_depth = 1;
               res.rate_value = history_rates[newest_slot];
               res.read_valid = 1'b1;
            end
         end
         MODE_READ_NEXT: begin
            // The cursor sticks one beyond the depth, so long walks stay past the end.
            if (read_depth < DEPTH + 1) begin
               read_depth++;
            end
            if (read_depth <= stored_entries) begin
               res.rate_value =
                  history_rates[(newest_slot + DEPTH - ((read_depth - 1) % DEPTH)) % DEPTH];
               res.read_valid = 1'b1;
            end
         end
         default: begin
            clear_history();
         end
      endcase
      res.peak_rate  = peak_seen;
      res.byte_total = bytes_seen;
      res.time_total = millis_seen;
      res.fill_count = stored_entries[FILL_W-1:0];
      return res;
   endfunction

   task automatic flag_failure(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         flag_failure($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic queue_request(mode_type m, logic [COUNT_W-1:0] count,
                                logic [INTERVAL_W-1:0] ms);
      req_type item;
      item.mode        = m;
      item.byte_count  = count;
      item.interval_ms = ms;
      queued_requests.push_back(item);
      requests_queued++;
   endtask

   // Draws an add request whose count and interval favour the interesting corners.
   task automatic queue_random_add();
      logic [COUNT_W-1:0]    count;
      logic [INTERVAL_W-1:0] ms;
      int unsigned           pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      count = $urandom();
      else if (pick < 75) count = $urandom_range(0, 100000);
      else if (pick < 90) count = {1'b1, 31'($urandom())};
      else if (pick < 95) count = 32'h7FFF_FFFF;
      else                count = 32'h8000_0000;
      pick = $urandom_range(0, 99);
      if (pick < 70)      ms = INTERVAL_W'($urandom_range(1, 65535));
      else if (pick < 85) ms = INTERVAL_W'($urandom_range(1, 16));
      else if (pick < 95) ms = '0;
      else                ms = 16'hFFFF;
      queue_request(MODE_ADD, count, ms);
   endtask

   // Fills the queue with random work: bursts of adds, history walks from the
   // newest entry down to well past the oldest, a rare clear, and noise.
   task automatic queue_random_phase(int unsigned target);
      int unsigned goal;
      int unsigned pick;
      int unsigned steps;
      goal = requests_queued + target;
      while (requests_queued < goal) begin
         pick = $urandom_range(0, 199);
         if (pick < 2) begin
            queue_request(MODE_CLEAR, $urandom(), INTERVAL_W'($urandom()));
         end else if (pick < 112) begin
            steps = $urandom_range(1, 8);
            repeat (steps) queue_random_add();
         end else if (pick < 162) begin
            // Most walks start from the newest entry; some continue an old cursor.
            if ($urandom_range(0, 9) != 0) begin
               queue_request(MODE_READ_FIRST, $urandom(), INTERVAL_W'($urandom()));
            end
            steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70)
                                                : $urandom_range(0, 12);
            repeat (steps) begin
               queue_request(MODE_READ_NEXT, $urandom(), INTERVAL_W'($urandom()));
            end
         end else begin
            queue_request(mode_type'($urandom_range(0, 3)), $urandom(),
                          INTERVAL_W'($urandom()));
         end
      end
   endtask

   // Blocks until every queued request has been accepted and answered.
   task automatic wait_for_drain();
      while (requests_accepted != requests_queued || awaited_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: a new request is offered only once the previous transfer
   // has happened, and the payload stays put while valid is high.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= queued_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: predicts on each request transfer and checks each response transfer.
   always @(posedge clock) begin
      rsp_type want;
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               flag_failure("response transfer with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               compare_field("rate_value", rsp_data.rate_value, want.rate_value);
               compare_field("read_valid", rsp_data.read_valid, want.read_valid);
               compare_field("peak_rate", rsp_data.peak_rate, want.peak_rate);
               compare_field("byte_total", rsp_data.byte_total, want.byte_total);
               compare_field("time_total", rsp_data.time_total, want.time_total);
               compare_field("fill_count", rsp_data.fill_count, want.fill_count);
            end
         end
         if (req_taken) begin
            awaited_results.push_back(next_history_result(req_data));
            requests_accepted++;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      clear_history();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with no idling on either side.
      queue_request(MODE_READ_FIRST, 32'd0, 16'd0);          // read on an empty ring
      queue_request(MODE_READ_NEXT, 32'd0, 16'd0);           // read-next with no read-first
      queue_request(MODE_ADD, 32'h7FFF_FFFF, 16'd1);         // largest rate for a nonzero interval
      queue_request(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF);      // minus one clamps to zero
      queue_request(MODE_ADD, 32'h8000_0000, 16'd0);         // zero interval, most negative count clamps to zero
      queue_request(MODE_ADD, 32'd0, 16'd1);
      queue_request(MODE_ADD, 32'd1000, 16'hFFFF);
      queue_request(MODE_READ_NEXT, 32'd0, 16'd0);           // cursor carried from above
      queue_request(MODE_READ_FIRST, 32'hFFFF_FFFF, 16'hFFFF);
      repeat (6) queue_request(MODE_READ_NEXT, 32'd0, 16'd0); // walks past the fill count
      queue_request(MODE_ADD, 32'd12345, 16'd7);             // add in the middle of a walk
      queue_request(MODE_READ_NEXT, 32'd0, 16'd0);
      queue_request(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
      queue_request(MODE_READ_FIRST, 32'd0, 16'd0);          // nothing left after clear
      queue_request(MODE_ADD, 32'h7FFF_FFFF, 16'hFFFF);
      queue_request(MODE_READ_NEXT, 32'd0, 16'd0);
      queue_request(MODE_ADD, 32'h5555_5555, 16'hAAAA);
      queue_request(MODE_ADD, 32'hAAAA_AAAA, 16'h5555);
      queue_request(MODE_READ_FIRST, 32'h5555_5555, 16'h5555);

      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Sender idle in about half of the cycles.
      @(posedge clock);
      send_idle_pct = 51;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Receiver stalling in about half of the cycles.
      @(posedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 51;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Both sides idling now and then.
      @(posedge clock);
      send_idle_pct  = 21;
      recv_stall_pct = 21;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Give the block time to show any stray response transfer.
      repeat (100) @(posedge clock);
      if (awaited_results.size() != 0) begin
         flag_failure("responses still outstanding at the end of the run");
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: several times the slowest expected run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
hdl/trhb_pkg.sv
hdl/trhb_ram.sv
hdl/trhb_ctrl.sv
hdl/trhb_dp.sv
hdl/traffic_rate_history_buffer_top.sv
verif/traffic_rate_history_buffer_top_tb.sv
